### rtl/lwgdd_pkg.sv
// ----------------------------------------------------------------------------
// lwgdd_pkg
// Sizes and codes shared by the lock wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lwgdd_pkg;

	localparam int THREADS = 16;
	localparam int LOCKS   = 16;

	localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int CW = $clog2(THREADS + 1);
	localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
	localparam int LCW = $clog2(LOCKS + 1);
	localparam int WCW = 5;

	localparam logic [WCW-1:0] WAITERS_MAX = 5'd31;

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_ACQUIRE = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_CHECK   = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_PATH       = 2'd1;
	localparam logic [1:0] ST_THREADFULL = 2'd2;
	localparam logic [1:0] ST_LOCKFULL   = 2'd3;

	typedef logic [63:0] id_t;

endpackage

`default_nettype wire

### rtl/lock_wait_graph_deadlock_detector_top.sv
// ----------------------------------------------------------------------------
// lock_wait_graph_deadlock_detector_top
// Lock ownership tables and wait-for graph with a stepwise depth-first search.
// ----------------------------------------------------------------------------
// Request, acquire and release: the key lookup is registered, then the table
// update and the result are made together; no new item is accepted before the result is loaded.
// A check tries each start node in turn and takes search steps (push, skip or
// pop of one edge); when a cycle is found it scans the path entries and emits
// the cycle path and a closing result. A stalled result holds the sequencer.
// Reset clears the lock tables, wait edges, counts and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module lock_wait_graph_deadlock_detector_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       opcode,
	input  wire lwgdd_pkg::id_t   req_thread,
	input  wire lwgdd_pkg::id_t   lock_id,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status,
	output lwgdd_pkg::id_t        path_thread,
	output logic                  last
);
	import lwgdd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_STEP  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [1:0] op_q;
	id_t        tid_q;
	id_t        key_q;

	id_t              slots_q [THREADS];
	logic [CW-1:0]    tcount_q;
	logic [THREADS-1:0] edges_q [THREADS];
	id_t              keys_q [LOCKS];
	id_t              owners_q [LOCKS];
	logic [WCW-1:0]   waiters_q [LOCKS];
	logic [LCW-1:0]   lcount_q;

	logic [TW-1:0]    path_q [THREADS];
	logic [CW-1:0]    cur_q [THREADS];
	logic [THREADS-1:0] onpath_q;
	logic [THREADS-1:0] dead_q;
	logic [TW-1:0]    v_q;
	logic [CW-1:0]    c_q;
	logic [CW-1:0]    len_q;
	logic [TW-1:0]    s_q;
	logic [TW-1:0]    hit_q;
	logic [CW-1:0]    i_q;
	logic             found_q;
	logic             sdone_q;

	logic          lhit_q, tuf_q, ffound_q;
	logic [LW-1:0] li_q, fidx_q;
	logic [TW-1:0] tu_q;

	logic          out_valid_q;
	logic [1:0]    status_q;
	id_t           pthread_q;
	logic          last_q;

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign path_thread = pthread_q;
	assign last        = last_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// key lookups
	logic          lhit, tuf, ffound;
	logic [LW-1:0] li, fidx;
	logic [TW-1:0] tu;
	always_comb begin
		lhit = 1'b0; li = '0; tuf = 1'b0; tu = '0; ffound = 1'b0; fidx = '0;
		for (int i = LOCKS - 1; i >= 0; i--) begin
			if (LCW'(i) < lcount_q && keys_q[i] == key_q && key_q != '0) begin
				lhit = 1'b1;
				li = LW'(i);
			end
			if (LCW'(i) < lcount_q && keys_q[i] == '0) begin
				ffound = 1'b1;
				fidx = LW'(i);
			end
		end
		for (int i = THREADS - 1; i >= 0; i--) begin
			if (CW'(i) < tcount_q && slots_q[i] == tid_q) begin
				tuf = 1'b1;
				tu = TW'(i);
			end
		end
	end

	// owner lookup
	id_t           owner;
	logic          tof;
	logic [TW-1:0] to_idx;
	always_comb begin
		owner = owners_q[li_q];
		tof = 1'b0;
		to_idx = '0;
		for (int i = THREADS - 1; i >= 0; i--) begin
			if (CW'(i) < tcount_q && slots_q[i] == owner) begin
				tof = 1'b1;
				to_idx = TW'(i);
			end
		end
	end

	logic          self_own;
	logic [1:0]    need;
	logic [CW:0]   need_sum;
	logic [TW-1:0] tu_new, to_new;
	always_comb begin
		self_own = (owner == tid_q);
		need = {1'b0, !tuf_q} + {1'b0, (!self_own && !tof)};
		need_sum = {1'b0, tcount_q} + (CW+1)'(need);
		tu_new = tuf_q ? tu_q : tcount_q[TW-1:0];
		to_new = self_own ? tu_new :
			(tof ? to_idx : TW'(tcount_q + CW'(!tuf_q)));
	end

	// wait row of the requester after a request
	logic [THREADS-1:0] req_row;
	always_comb begin
		req_row = tuf_q ? edges_q[tu_new] : '0;
		if (!self_own) begin
			req_row[to_new] = 1'b1;
		end
	end

	logic [1:0] exec_st;
	always_comb begin
		exec_st = ST_OK;
		if (op_q == OP_REQUEST && lhit_q && need_sum > (CW+1)'(THREADS)) begin
			exec_st = ST_THREADFULL;
		end
		if (op_q == OP_ACQUIRE && key_q != '0 && !lhit_q && !ffound_q &&
			lcount_q == LCW'(LOCKS)) begin
			exec_st = ST_LOCKFULL;
		end
	end

	// next neighbor of the top node
	logic [THREADS-1:0] tvalid, nmask;
	logic               nfound;
	logic [TW-1:0]      nidx;
	always_comb begin
		for (int i = 0; i < THREADS; i++) begin
			tvalid[i] = (CW'(i) < tcount_q);
		end
		nmask = edges_q[v_q] & tvalid & ({THREADS{1'b1}} << c_q);
		nfound = 1'b0;
		nidx = '0;
		for (int i = THREADS - 1; i >= 0; i--) begin
			if (nmask[i]) begin
				nfound = 1'b1;
				nidx = TW'(i);
			end
		end
	end

	logic [TW-1:0] rd_addr, rd_node;
	logic [CW-1:0] rd_cur;
	logic [CW-1:0] len_m2;
	always_comb begin
		len_m2 = len_q - CW'(2);
		rd_addr = (state_q == S_EMIT) ? i_q[TW-1:0] : len_m2[TW-1:0];
		rd_node = path_q[rd_addr];
		rd_cur = cur_q[rd_addr];
	end

	logic [TW-1:0] top_idx;
	assign top_idx = TW'(len_q - CW'(1));

	// a result item is loaded this cycle
	logic out_set;
	always_comb begin
		unique case (state_q)
			S_EXEC:  out_set = out_free;
			S_START: out_set = out_free && (sdone_q || CW'(s_q) >= tcount_q);
			S_EMIT:  out_set = out_free && (i_q == len_q || found_q || rd_node == hit_q);
			default: out_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tcount_q <= '0;
			lcount_q <= '0;
			onpath_q <= '0;
			dead_q <= '0;
			for (int i = 0; i < THREADS; i++) begin
				edges_q[i] <= '0;
			end
			for (int i = 0; i < LOCKS; i++) begin
				keys_q[i] <= '0;
				owners_q[i] <= '0;
				waiters_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						tid_q <= req_thread;
						key_q <= lock_id;
						if (opcode == OP_CHECK) begin
							dead_q <= '0;
							s_q <= '0;
							sdone_q <= 1'b0;
							state_q <= S_START;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					lhit_q <= lhit; li_q <= li;
					tuf_q <= tuf; tu_q <= tu;
					ffound_q <= ffound; fidx_q <= fidx;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						status_q <= exec_st;
						pthread_q <= '0;
						last_q <= 1'b1;
						state_q <= S_IDLE;
						case (op_q)
							OP_REQUEST: begin
								if (lhit_q && exec_st == ST_OK) begin
									if (!tuf_q) begin
										slots_q[tu_new] <= tid_q;
									end
									if (!self_own && !tof) begin
										slots_q[to_new] <= owner;
										edges_q[to_new] <= '0;
									end
									edges_q[tu_new] <= req_row;
									tcount_q <= need_sum[CW-1:0];
									if (waiters_q[li_q] < WAITERS_MAX) begin
										waiters_q[li_q] <= waiters_q[li_q] + WCW'(1);
									end
								end
							end
							OP_ACQUIRE: begin
								if (key_q != '0 && !lhit_q) begin
									if (ffound_q) begin
										keys_q[fidx_q] <= key_q;
										owners_q[fidx_q] <= tid_q;
										waiters_q[fidx_q] <= '0;
									end else if (exec_st == ST_OK) begin
										keys_q[lcount_q[LW-1:0]] <= key_q;
										owners_q[lcount_q[LW-1:0]] <= tid_q;
										waiters_q[lcount_q[LW-1:0]] <= '0;
										lcount_q <= lcount_q + LCW'(1);
									end
								end else if (lhit_q) begin
									if (waiters_q[li_q] != '0) begin
										waiters_q[li_q] <= waiters_q[li_q] - WCW'(1);
									end
									if (tuf_q && tof) begin
										edges_q[tu_q][to_idx] <= 1'b0;
									end
									owners_q[li_q] <= tid_q;
								end
							end
							OP_RELEASE: begin
								if (lhit_q && waiters_q[li_q] == '0) begin
									keys_q[li_q] <= '0;
									owners_q[li_q] <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_START: begin
					if (sdone_q || CW'(s_q) >= tcount_q) begin
						if (out_free) begin
							status_q <= ST_OK;
							pthread_q <= '0;
							last_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (dead_q[s_q]) begin
						s_q <= s_q + TW'(1);
						sdone_q <= (s_q == TW'(THREADS - 1));
					end else begin
						onpath_q <= {{(THREADS-1){1'b0}}, 1'b1} << s_q;
						path_q[0] <= s_q;
						v_q <= s_q;
						c_q <= '0;
						len_q <= CW'(1);
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (nfound) begin
						if (onpath_q[nidx]) begin
							hit_q <= nidx;
							i_q <= '0;
							found_q <= 1'b0;
							state_q <= S_EMIT;
						end else if (dead_q[nidx]) begin
							c_q <= CW'(nidx) + CW'(1);
						end else begin
							cur_q[top_idx] <= CW'(nidx) + CW'(1);
							path_q[len_q[TW-1:0]] <= nidx;
							onpath_q[nidx] <= 1'b1;
							v_q <= nidx;
							c_q <= '0;
							len_q <= len_q + CW'(1);
						end
					end else begin
						onpath_q[v_q] <= 1'b0;
						dead_q[v_q] <= 1'b1;
						len_q <= len_q - CW'(1);
						if (len_q == CW'(1)) begin
							s_q <= s_q + TW'(1);
							sdone_q <= (s_q == TW'(THREADS - 1));
							state_q <= S_START;
						end else begin
							v_q <= rd_node;
							c_q <= rd_cur;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (i_q == len_q) begin
							status_q <= ST_PATH;
							pthread_q <= slots_q[hit_q];
							last_q <= 1'b1;
							onpath_q <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + CW'(1);
							if (found_q || rd_node == hit_q) begin
								found_q <= 1'b1;
								status_q <= ST_PATH;
								pthread_q <= slots_q[rd_node];
								last_q <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### verif/tb_lock_wait_graph_deadlock_detector_top.sv
// ----------------------------------------------------------------------------
// tb_lock_wait_graph_deadlock_detector_top
// Drives request, acquire, release and check items into the deadlock detector,
// predicts the lock tables, the wait-for graph and every reported cycle path,
// and compares each result item in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lock_wait_graph_deadlock_detector_top;
	import lwgdd_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		id_t        tid;
		id_t        lid;
	} event_t;

	typedef struct packed {
		logic [1:0] st;
		id_t        who;
		logic       lst;
	} answer_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] opcode;
	id_t        req_thread;
	id_t        lock_id;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] status;
	id_t        path_thread;
	logic       last;

	lock_wait_graph_deadlock_detector_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .req_thread(req_thread), .lock_id(lock_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .path_thread(path_thread), .last(last)
	);

	// predicted state
	id_t             node_ids [THREADS];
	int              node_cnt = 0;
	logic [THREADS-1:0] waits_on [THREADS];
	id_t             lk_key [LOCKS];
	id_t             lk_own [LOCKS];
	int              lk_wait [LOCKS];
	int              lk_cnt = 0;
	int              walk [THREADS+1];
	int              walk_len;
	int              hit;
	logic [THREADS-1:0] on_walk;
	logic [THREADS-1:0] cleared;

	event_t  pending [$];
	answer_t expected [$];
	int      errors = 0;
	int      cycles = 0;
	int      n_sent = 0;
	int      n_queued = 0;
	int      n_cycles_found = 0;
	bit      hold_off = 1'b0;
	bit      in_taken;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int node_of(id_t id);
		for (int i = 0; i < node_cnt; i++)
			if (node_ids[i] == id) return i;
		return -1;
	endfunction

	function automatic int lock_of(id_t key);
		if (key == 0) return -1;
		for (int i = 0; i < lk_cnt; i++)
			if (lk_key[i] == key) return i;
		return -1;
	endfunction

	function automatic int add_node(id_t id);
		int t;
		t = node_of(id);
		if (t >= 0 || node_cnt >= THREADS) return t;
		node_ids[node_cnt] = id;
		waits_on[node_cnt] = '0;
		node_cnt++;
		return node_cnt - 1;
	endfunction

	function automatic bit dfs(int v);
		if (on_walk[v]) begin
			hit = v;
			return 1;
		end
		if (cleared[v]) return 0;
		on_walk[v] = 1'b1;
		walk[walk_len++] = v;
		for (int n = 0; n < node_cnt; n++)
			if (waits_on[v][n] && dfs(n)) return 1;
		on_walk[v] = 1'b0;
		walk_len--;
		cleared[v] = 1'b1;
		return 0;
	endfunction

	function automatic void push(logic [1:0] st, id_t who, logic lst);
		answer_t a;
		a.st = st; a.who = who; a.lst = lst;
		expected.push_back(a);
	endfunction

	function automatic void predict_event(event_t e);
		int li, need, tu, to, slot, p;
		li = lock_of(e.lid);
		case (e.op)
			OP_REQUEST: if (li >= 0) begin
				need = 0;
				if (node_of(e.tid) < 0) need++;
				if (lk_own[li] != e.tid && node_of(lk_own[li]) < 0) need++;
				if (node_cnt + need > THREADS) begin
					push(ST_THREADFULL, '0, 1'b1);
					return;
				end
				tu = add_node(e.tid);
				to = add_node(lk_own[li]);
				if (lk_wait[li] < WAITERS_MAX) lk_wait[li]++;
				if (tu >= 0 && to >= 0 && tu != to) waits_on[tu][to] = 1'b1;
			end
			OP_ACQUIRE: begin
				if (e.lid != 0 && li < 0) begin
					slot = lk_cnt;
					for (int i = 0; i < lk_cnt; i++)
						if (lk_key[i] == 0) begin
							slot = i;
							break;
						end
					if (slot >= LOCKS) begin
						push(ST_LOCKFULL, '0, 1'b1);
						return;
					end
					if (slot == lk_cnt) lk_cnt++;
					lk_key[slot] = e.lid;
					lk_own[slot] = e.tid;
					lk_wait[slot] = 0;
				end else if (li >= 0) begin
					tu = node_of(e.tid);
					to = node_of(lk_own[li]);
					if (lk_wait[li] > 0) lk_wait[li]--;
					if (tu >= 0 && to >= 0) waits_on[tu][to] = 1'b0;
					lk_own[li] = e.tid;
				end
			end
			OP_RELEASE: if (li >= 0 && lk_wait[li] == 0) begin
				lk_key[li] = '0;
				lk_own[li] = '0;
			end
			OP_CHECK: begin
				cleared = '0;
				for (int s = 0; s < node_cnt; s++) begin
					on_walk = '0;
					walk_len = 0;
					if (dfs(s)) begin
						p = 0;
						while (p < walk_len && walk[p] != hit) p++;
						for (int i = p; i < walk_len; i++)
							push(ST_PATH, node_ids[walk[i]], 1'b0);
						push(ST_PATH, node_ids[hit], 1'b1);
						n_cycles_found++;
						return;
					end
				end
			end
		endcase
		push(ST_OK, '0, 1'b1);
	endfunction

	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
	end

	// driver
	int in_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			req_thread <= '0;
			lock_id <= '0;
			in_gap <= 0;
		end else if (!in_valid || in_taken) begin
			if (in_gap > 0 || hold_off || pending.size() == 0) begin
				in_valid <= 1'b0;
				if (in_gap > 0) in_gap <= in_gap - 1;
			end else begin
				event_t e;
				e = pending.pop_front();
				predict_event(e);
				n_sent++;
				in_valid <= 1'b1;
				opcode <= e.op;
				req_thread <= e.tid;
				lock_id <= e.lid;
				in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// monitor
	int out_gap;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected.size() == 0) begin
				$display("%0t: unexpected result st=%0d who=%h last=%0d",
					$time, status, path_thread, last);
				errors++;
			end else begin
				answer_t a;
				a = expected.pop_front();
				if (a.st !== status || a.who !== path_thread || a.lst !== last) begin
					$display("%0t: mismatch expected st=%0d who=%h last=%0d actual st=%0d who=%h last=%0d",
						$time, a.st, a.who, a.lst, status, path_thread, last);
					errors++;
				end
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else if (out_gap > 0) begin
			out_stall <= 1'b1;
			out_gap <= out_gap - 1;
		end else if (out_valid && !out_stall) begin
			out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void add(logic [1:0] op, id_t tid, id_t lid);
		event_t e;
		e.op = op; e.tid = tid; e.lid = lid;
		pending.push_back(e);
		n_queued++;
	endfunction

	function automatic id_t rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic drain();
		while (pending.size() != 0 || expected.size() != 0 || in_valid) @(posedge clk);
	endtask

	initial begin
		id_t tpool [8];
		id_t lpool [6];
		int nt, nl;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		#1 arst_n = 1'b1;

		// directed: empty check, zero lock, unknown locks, two-thread deadlock
		add(OP_CHECK, '0, '0);
		add(OP_REQUEST, 64'h1, '0);
		add(OP_ACQUIRE, 64'h1, '0);
		add(OP_RELEASE, 64'h1, '0);
		add(OP_REQUEST, 64'h1, 64'h99);
		add(OP_RELEASE, 64'h1, 64'h99);
		add(OP_ACQUIRE, '1, '1);
		add(OP_ACQUIRE, '0, 64'h1);
		add(OP_REQUEST, '1, 64'h1);
		add(OP_REQUEST, '0, '1);
		add(OP_REQUEST, '1, '1);
		add(OP_CHECK, '0, '0);
		add(OP_ACQUIRE, '1, 64'h1);
		add(OP_RELEASE, '1, 64'h1);
		add(OP_CHECK, '1, '1);
		drain();

		// lock table full, then thread table full via one lock
		for (int i = 0; i < LOCKS + 1; i++) add(OP_ACQUIRE, 64'h500, 64'h1000 + i);
		for (int i = 0; i < THREADS + 2; i++) add(OP_REQUEST, 64'h2000 + i, 64'h1000);
		for (int i = 0; i < 40; i++) add(OP_REQUEST, 64'h2000, 64'h1001);
		add(OP_ACQUIRE, 64'h2001, 64'h1000);
		add(OP_CHECK, '0, '0);
		for (int i = 0; i < LOCKS; i++) add(OP_RELEASE, '0, 64'h1000 + i);
		hold_off = 1'b1;
		while (expected.size() != 0 || in_valid) @(posedge clk);
		repeat (20) @(posedge clk);
		hold_off = 1'b0;

		// random: small pools so that cycles form often
		while (n_queued < 400) begin
			nt = $urandom_range(2, 8);
			nl = $urandom_range(1, 6);
			for (int i = 0; i < 8; i++) tpool[i] = rnd64();
			for (int i = 0; i < 6; i++) lpool[i] = rnd64() | 64'h1;
			for (int j = 0; j < 80; j++) begin
				logic [1:0] op;
				id_t t, l;
				op = 2'($urandom_range(0, 3));
				t = tpool[$urandom_range(0, nt - 1)];
				l = lpool[$urandom_range(0, nl - 1)];
				if ($urandom_range(0, 19) == 0) t = rnd64();
				if ($urandom_range(0, 19) == 0) l = rnd64();
				if ($urandom_range(0, 29) == 0) l = '0;
				add(op, t, l);
			end
			for (int i = 0; i < nl; i++)
				for (int r = 0; r < 3; r++) add(OP_RELEASE, '0, lpool[i]);
			for (int i = 0; i < nl; i++)
				for (int r = 0; r < 32; r++) add(OP_ACQUIRE, tpool[0], lpool[i]);
			for (int i = 0; i < nl; i++) add(OP_RELEASE, '0, lpool[i]);
		end
		drain();
		repeat (200) @(posedge clk);
		$display("tb: %0d items with random gaps and stalls, %0d deadlock paths, %0d mismatches",
			n_sent, n_cycles_found, errors);
		if (errors == 0 && expected.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
